// ----- design/bsr_pkg.sv -----
// shared types and codes for the bounded stack with removal
`default_nettype none

package bsr_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  localparam int OP_BITS    = 2;
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 6;
  localparam int COUNT_BITS = 7;
  localparam int CAP_BITS   = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    push_wr;
    logic    fill_inc;
    logic    fill_dec;
    logic    rd_top;
    logic    rd_next;
    logic    shift_step;
    logic    res_load;
    logic    res_mem;
    status_t res_status;
  } cmd_t;

  // conditions reported by the datapath
  typedef struct packed {
    logic full;
    logic empty;
    logic badpos;
    logic top_only;
    logic shift_more;
  } flags_t;

endpackage

`default_nettype wire

// ----- design/bsr_req_if.sv -----
// request channel: operation, word to push and position to remove
`default_nettype none

interface bsr_req_if import bsr_pkg::*;;
  logic                         valid;
  logic                         ready;
  op_t                          op;
  logic signed [VALUE_BITS-1:0] push_value;
  logic        [POS_BITS-1:0]   position;

  modport source (output valid, output op, output push_value, output position, input ready);
  modport sink   (input valid, input op, input push_value, input position, output ready);
endinterface

`default_nettype wire

// ----- design/bsr_rsp_if.sv -----
// result channel: data, status and count after the operation
`default_nettype none

interface bsr_rsp_if import bsr_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] data;
  status_t                      status;
  logic        [COUNT_BITS-1:0] count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

`default_nettype wire

// ----- design/bsr_ctrl.sv -----
// controller state machine: sequencing of push, pop, peek and remove
`default_nettype none

module bsr_ctrl import bsr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  input  op_t    req_op,
  output logic   req_ready,
  output logic   rsp_valid,
  input  logic   rsp_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign take      = req_valid && req_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (req_op)
            OP_PUSH: begin
              cmd.res_load = 1'b1;
              if (flags.full) begin
                cmd.res_status = STAT_FULL;
              end else begin
                cmd.push_wr  = 1'b1;
                cmd.fill_inc = 1'b1;
              end
            end
            OP_POP: begin
              if (flags.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_EMPTY;
              end else begin
                cmd.fill_dec = 1'b1;
                cmd.rd_top   = 1'b1;
                state_next   = S_READ;
              end
            end
            OP_PEEK: begin
              if (flags.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_READ;
              end
            end
            OP_REMOVE: begin
              if (flags.badpos) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_BADPOS;
              end else if (flags.top_only) begin
                cmd.fill_dec = 1'b1;
                cmd.res_load = 1'b1;
              end else begin
                cmd.rd_next = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_mem  = 1'b1;
        state_next   = S_IDLE;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!flags.shift_more) begin
          cmd.fill_dec = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_ready) rsp_valid_next = 1'b0;
    if (cmd.res_load) rsp_valid_next = 1'b1;
  end

endmodule

`default_nettype wire

// ----- design/bsr_datapath.sv -----
// datapath: entry memory, fill count, capacity register, shift pointer, result register
`default_nettype none

module bsr_datapath import bsr_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic        [CAP_BITS-1:0]   cfg_wr_data,
  input  logic signed [VALUE_BITS-1:0] push_value,
  input  logic        [POS_BITS-1:0]   position,
  input  cmd_t                         cmd,
  output flags_t                       flags,
  output logic signed [VALUE_BITS-1:0] rsp_data,
  output status_t                      rsp_status,
  output logic        [COUNT_BITS-1:0] rsp_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > CAP_BITS) ? CW : CAP_BITS) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic signed [WORD_BITS-1:0] mem [DEPTH];
  logic signed [WORD_BITS-1:0] rdata;
  logic        [CW-1:0]        fill, fill_next;
  logic        [CAP_BITS-1:0]  capacity;
  logic        [AW-1:0]        ptr;
  logic        [XW-1:0]        fill_x, pos_x, cap_x, ptr_x, rd_addr_x;

  assign fill_x = XW'(fill);
  assign pos_x  = XW'(position);
  assign cap_x  = XW'(capacity);
  assign ptr_x  = XW'(ptr);

  assign flags.full       = (fill_x >= DEPTH_X) || (fill_x >= cap_x);
  assign flags.empty      = (fill == '0);
  assign flags.badpos     = (pos_x >= fill_x);
  assign flags.top_only   = (pos_x + XW'(1) == fill_x);
  assign flags.shift_more = (ptr_x + XW'(2) < fill_x);

  always_comb begin
    fill_next = fill;
    if (cmd.fill_inc) fill_next = fill + CW'(1);
    if (cmd.fill_dec) fill_next = fill - CW'(1);
  end

  always_comb begin
    if (cmd.rd_top) begin
      rd_addr_x = fill_x - XW'(1);
    end else if (cmd.rd_next) begin
      rd_addr_x = pos_x + XW'(1);
    end else begin
      rd_addr_x = ptr_x + XW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      capacity <= CAP_RESET;
    end else begin
      fill <= fill_next;
      if (cfg_wr_en) capacity <= cfg_wr_data;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[fill[AW-1:0]] <= WORD_BITS'(push_value);
    end else if (cmd.shift_step) begin
      mem[ptr] <= rdata;
    end
    rdata <= mem[rd_addr_x[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_next) begin
      ptr <= pos_x[AW-1:0];
    end else if (cmd.shift_step) begin
      ptr <= ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_data   <= cmd.res_mem ? VALUE_BITS'(rdata) : '1;
      rsp_status <= cmd.res_status;
      rsp_count  <= COUNT_BITS'(fill_next);
    end
  end

endmodule

`default_nettype wire

// ----- design/bounded_stack_with_removal.sv -----
// top level of the bounded stack with removal
//
//  channel   role      transfer when          payload
//  req       sink      req.valid & req.ready  op, push_value, position
//  rsp       source    rsp.valid & rsp.ready  data, status, count
//  cfg       write     cfg_wr_en              cfg_wr_data -> capacity
//
// push, refused requests and a remove of the top entry: result in the cycle after the transfer
// pop and peek: result loaded in S_READ, from the registered memory read
// remove below the top: entries above the position move down in S_SHIFT, one entry moved per cycle
// over the single write port of the entry memory
// rst is synchronous: count clears, capacity returns to 64, entries stay unwritten
// a new request is taken only in idle and when the result register is empty or being taken
`default_nettype none

module bounded_stack_with_removal import bsr_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  bsr_req_if.sink             req,
  bsr_rsp_if.source           rsp,
  input  logic                cfg_wr_en,
  input  logic [CAP_BITS-1:0] cfg_wr_data
);

  // command and status between controller and datapath
  cmd_t   cmd;
  flags_t flags;

  // sequencing of each request
  bsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // storage, counters and the result register
  bsr_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_value  (req.push_value),
    .position    (req.position),
    .cmd         (cmd),
    .flags       (flags),
    .rsp_data    (rsp.data),
    .rsp_status  (rsp.status),
    .rsp_count   (rsp.count)
  );

`ifndef SYNTHESIS
  // a request is only taken when the result register can hold its result
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!rsp.valid || rsp.ready))
    else $error("request taken while result register still occupied");

  // push result is valid in the cycle after the transfer
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == OP_PUSH) |=> rsp.valid)
    else $error("push result missing one cycle after transfer");

  // peek of a non-empty stack completes through S_READ, after the registered memory read
  a_peek_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == OP_PEEK && !flags.empty) |=> ##1 rsp.valid)
    else $error("peek result missing two cycles after transfer");

  // any refused request returns all ones
  a_err_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STAT_OK) |-> (rsp.data == '1))
    else $error("error result carries data other than all ones");
`endif

endmodule

`default_nettype wire

// ----- verif/bsr_tb_pkg.sv -----
// shadow copy of the stack and store of awaited results for the stack testbench
`timescale 1ns / 100ps

package bsr_tb_pkg;
  import bsr_pkg::*;

  localparam int STACK_DEPTH = 64;

  typedef struct {
    logic signed [VALUE_BITS-1:0] data;
    status_t                      status;
    logic        [COUNT_BITS-1:0] count;
  } stack_result_t;

  class stack_result_board;
    logic signed [VALUE_BITS-1:0] words [STACK_DEPTH];
    int unsigned   fill;
    int unsigned   capacity;
    int unsigned   errors;
    stack_result_t awaited_results [$];

    function new();
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity = value;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // works out the result of one accepted request and files it
    function void note_request(op_t op, logic signed [VALUE_BITS-1:0] word,
                               logic [POS_BITS-1:0] pos);
      stack_result_t r;
      int unsigned   limit;
      r.data   = '1;
      r.status = STAT_OK;
      limit    = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
      case (op)
        OP_PUSH: begin
          if (fill >= limit) begin
            r.status = STAT_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            fill--;
            r.data = words[fill];
          end
        end
        OP_REMOVE: begin
          if (pos >= fill) begin
            r.status = STAT_BADPOS;
          end else begin
            for (int i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        default: begin
          if (fill == 0) r.status = STAT_EMPTY;
          else r.data = words[fill-1];
        end
      endcase
      r.count = fill[COUNT_BITS-1:0];
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_BITS-1:0] data, status_t status,
                               logic [COUNT_BITS-1:0] count);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: data %0d status %0d count %0d", data, status, count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (data !== want.data) begin
        $error("data: expected %0d, got %0d", want.data, data);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- verif/tb_bounded_stack_with_removal.sv -----
// top-level testbench of the bounded stack with removal
`timescale 1ns / 100ps

module tb_bounded_stack_with_removal;
  import bsr_pkg::*;
  import bsr_tb_pkg::*;

  // cycles to let pass once the last result is in (longest remove shifts 63 entries)
  localparam int SETTLE_CYCLES  = 70;
  // cycles without any transfer before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENT_ITEMS  = 80;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [CAP_BITS-1:0] cfg_wr_data;

  bsr_req_if req_ch ();
  bsr_rsp_if rsp_ch ();

  bounded_stack_with_removal dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  stack_result_board board = new();

  // idling percentages, changed per phase by the stimulus, and the watchdog's quiet count
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  always #1 clk = ~clk;

  // result side back-pressure, updated on the falling edge
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: everything sampled on the rising edge; the result is checked before
  // the request of the same edge is noted, as a result never belongs to a request
  // that is only now being transferred
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_result(rsp_ch.data, rsp_ch.status, rsp_ch.count);
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_ch.op, req_ch.push_value, req_ch.position);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // one request transfer; gaps before it at the current idling rate, valid left high
  // afterwards so back-to-back requests never drop it in between
  task automatic send_request(op_t op, logic signed [VALUE_BITS-1:0] word,
                              logic [POS_BITS-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.push_value <= word;
    req_ch.position   <= pos;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // stop sending and hold off until every awaited result has been transferred
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // capacity is only written with the block idle and any shifting long finished
  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_capacity(value);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // mostly a position that holds an entry, now and then anything the field allows
  function automatic logic [POS_BITS-1:0] pick_position(int unsigned fill);
    if (fill != 0 && $urandom_range(3) != 0) return POS_BITS'($urandom_range(fill - 1));
    return POS_BITS'($urandom_range(63));
  endfunction

  // drift the fill towards a target so both full and empty get visited
  function automatic op_t pick_op(int unsigned fill, int unsigned target);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < ((fill < target) ? 70 : 20)) return OP_PUSH;
    roll = $urandom_range(99);
    if (roll < 45) return OP_POP;
    if (roll < 75) return OP_REMOVE;
    return OP_PEEK;
  endfunction

  // one random segment at a given capacity; the target fill moves every 40 transfers
  task automatic run_segment(logic [CAP_BITS-1:0] cap, int unsigned first_target);
    int unsigned target;
    int unsigned cap_eff;
    op_t         op;
    write_capacity(cap);
    cap_eff = (cap > STACK_DEPTH) ? STACK_DEPTH : cap;
    target  = first_target;
    for (int k = 0; k < SEGMENT_ITEMS; k++) begin
      if (k % 40 == 39) begin
        case ($urandom_range(3))
          0:       target = 0;
          1:       target = STACK_DEPTH;
          2:       target = cap_eff;
          default: target = $urandom_range(STACK_DEPTH);
        endcase
      end
      // occasional full pause of the sender until the result side has caught up
      if ($urandom_range(49) == 0) drain_results();
      op = pick_op(board.fill, target);
      send_request(op, pick_word(), pick_position(board.fill));
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_PUSH;
    req_ch.push_value <= '0;
    req_ch.position   <= '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty stack at reset capacity
    send_request(OP_POP,    pick_word(), 6'd0);
    send_request(OP_PEEK,   pick_word(), 6'd17);
    send_request(OP_REMOVE, pick_word(), 6'd0);
    send_request(OP_REMOVE, pick_word(), 6'd63);
    // extremes of the word
    send_request(OP_PUSH, 32'sh8000_0000, 6'd63);
    send_request(OP_PUSH, 32'sh7fff_ffff, 6'd0);
    send_request(OP_PUSH, -1,             6'd42);
    send_request(OP_PUSH, 0,              6'd21);
    send_request(OP_PUSH, 1,              6'd5);
    send_request(OP_PEEK, pick_word(), 6'd0);
    // remove just past the top, then the top itself, then the bottom with a full shift
    send_request(OP_REMOVE, pick_word(), 6'd5);
    send_request(OP_REMOVE, pick_word(), 6'd4);
    send_request(OP_REMOVE, pick_word(), 6'd0);
    send_request(OP_POP,    pick_word(), 6'd9);

    // capacity reached, then zero capacity, then capacity below the fill
    write_capacity(7'd2);
    send_request(OP_PUSH, pick_word(), 6'd0);
    write_capacity(7'd0);
    send_request(OP_PUSH, pick_word(), 6'd0);
    send_request(OP_PEEK, pick_word(), 6'd0);
    write_capacity(7'd1);
    send_request(OP_PUSH,   pick_word(), 6'd0);
    send_request(OP_POP,    pick_word(), 6'd0);
    send_request(OP_PUSH,   pick_word(), 6'd0);
    send_request(OP_REMOVE, pick_word(), 6'd0);
    send_request(OP_POP,    pick_word(), 6'd0);

    // random: no idling, capacity above depth to fill all 64, then a lowered capacity
    send_idle_pct = 0;  stall_pct = 0;
    run_segment(7'd127, STACK_DEPTH);
    run_segment(7'd3, 0);
    // sender mostly idle
    send_idle_pct = 79; stall_pct = 0;
    run_segment(7'd64, STACK_DEPTH);
    run_segment(7'd0, 32);
    // receiver mostly stalling
    send_idle_pct = 0;  stall_pct = 79;
    run_segment(7'd40, 40);
    run_segment(7'd1, 0);
    // light idling on both sides
    send_idle_pct = 6;  stall_pct = 6;
    run_segment(7'd64, STACK_DEPTH);
    run_segment(CAP_BITS'($urandom_range(1, 64)), $urandom_range(STACK_DEPTH));

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
